/* hw/rtl/spatial_slot_table_with_far_eviction_assert.svh */
// Assertion macros shared by the slot table checker.
// Needs clk and rst_n visible in the scope that uses them.
`ifndef SPATIAL_SLOT_TABLE_WITH_FAR_EVICTION_ASSERT_SVH
`define SPATIAL_SLOT_TABLE_WITH_FAR_EVICTION_ASSERT_SVH

// same-cycle implication
`define SST_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot table assertion failed");

// next-cycle implication
`define SST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot table assertion failed");

`endif

/* hw/rtl/sst_pkg.sv */
// Shared constants for the spatial slot table: opcodes, status codes,
// register indexes and word layouts. No dependencies.
package sst_pkg;

    localparam int OPCODE_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int POS_W      = 16;
    localparam int SLOT_W     = 6;
    localparam int FREE_W     = 7;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 72;

    localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOCK   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_EVICT  = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_VICTIM = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT = 3'd5;

    // result word layout, lowest bit of each field
    localparam int OUT_STATUS_LSB   = 0;
    localparam int OUT_NEW_SLOT_LSB = 2;
    localparam int OUT_VVALID_LSB   = 8;
    localparam int OUT_VSLOT_LSB    = 9;
    localparam int OUT_VX_LSB       = 15;
    localparam int OUT_VY_LSB       = 31;
    localparam int OUT_VZ_LSB       = 47;
    localparam int OUT_INSIDE_LSB   = 63;
    localparam int OUT_FREE_LSB     = 64;

endpackage

/* hw/rtl/spatial_slot_table_with_far_eviction.sv */
// Spatial slot table with far-first eviction: top level.
// Uses sst_pkg and sst_ram (slot position store).
//
//   channel   handshake                      payload
//   s_axis    s_axis_tvalid / s_axis_tready  tuser: opcode; tdata: pos, slot, lock
//   m_axis    m_axis_tvalid / m_axis_tready  tdata: status .. free_count
//   cfg       cfg_we                         cfg_index, cfg_data
//
// Remove and set-lock go from accept straight to the result. Add with a free
// slot walks the valid bits from slot 0, one valid bit a cycle, to the lowest
// free one. Evict, and add on a full table, sweep the position RAM read port
// one slot a cycle through a three-stage distance pipeline.
// Reset clears valid and lock bits at once; positions stay unwritten.
// One item at a time; a result waiting in the output register does not block
// the next accept, only the next result.
module spatial_slot_table_with_far_eviction #(
    parameter int SLOTS      = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // pos_x, pos_y, pos_z, slot, lock_value
    input  logic [sst_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // opcode
    input  logic [sst_pkg::OPCODE_W-1:0]     s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status, new_slot, victim_valid, victim_slot, victim_x, victim_y,
    // victim_z, victim_inside, free_count
    output logic [sst_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                             cfg_we,
    input  logic [sst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sst_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SW  = $clog2(SLOTS);
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int EW  = ((COORD_BITS > 17) ? COORD_BITS : 17) + 2;
    localparam int QW  = 2 * EW;
    localparam int DSW = QW + 2;
    localparam int PW  = 3 * COORD_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_PICK = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]       state_reg;
    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] locked_reg;
    logic [CW-1:0]    free_reg;
    logic [CW-1:0]    idx_reg;
    logic             out_valid_reg;
    logic [sst_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic signed [15:0] ox_reg, oy_reg, oz_reg, ymin_reg, ymax_reg;
    logic [14:0]        span_reg;

    logic [sst_pkg::OPCODE_W-1:0] op_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg, pz_reg;

    logic [sst_pkg::STATUS_W-1:0] res_status_reg;
    logic [SW-1:0]                res_new_slot_reg;
    logic                         res_vvalid_reg;
    logic [SW-1:0]                res_vslot_reg;
    logic [PW-1:0]                res_vpos_reg;
    logic                         res_inside_reg;

    logic          p0_v_reg, a_v_reg, b_v_reg;
    logic [SW-1:0] p0_idx_reg, a_idx_reg, b_idx_reg;
    logic          p0_cand_reg, a_cand_reg, b_cand_reg;
    logic [PW-1:0] a_pos_reg, b_pos_reg;
    logic          a_inside_reg, b_inside_reg;
    logic [EW-1:0] a_ax_reg, a_ay_reg, a_az_reg;
    logic [QW-1:0] b_qx_reg, b_qy_reg, b_qz_reg;

    logic           bo_hit_reg, ba_hit_reg;
    logic [DSW-1:0] bo_d_reg, ba_d_reg;
    logic [SW-1:0]  bo_idx_reg, ba_idx_reg;
    logic [PW-1:0]  bo_pos_reg, ba_pos_reg;
    logic           ba_inside_reg;

    logic                         in_acc;
    logic [sst_pkg::OPCODE_W-1:0] in_op;
    logic [sst_pkg::SLOT_W-1:0]   in_slot;
    logic [SW-1:0]                in_sidx;
    logic                         in_hit;
    logic [SW-1:0]                idx_s;
    logic                         issue;
    logic                         find_hit;
    logic                         vic_hit;
    logic [SW-1:0]                vic_idx;
    logic [PW-1:0]                vic_pos;
    logic                         vic_inside;
    logic                         pick_add;
    logic                         out_load;
    logic                         mem_we;
    logic [SW-1:0]                mem_waddr;
    logic [PW-1:0]                mem_rdata;

    logic signed [COORD_BITS-1:0] rx, ry, rz;
    logic signed [EW-1:0]         ex, ey, ez, dx, dy, dz;
    logic signed [EW-1:0]         lox, hix, loz, hiz, ylo, yhi, span_e;
    logic                         r_inside;
    logic [DSW-1:0]               dsum;
    logic signed [COORD_BITS-1:0] vx, vy, vz;
    logic signed [31:0]           vx32, vy32, vz32;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_op    = s_axis_tuser;
    assign in_slot  = s_axis_tdata[53:48];
    assign in_sidx  = SW'(in_slot);
    assign in_hit   = (in_slot < SLOTS) && valid_reg[in_sidx];
    assign idx_s    = idx_reg[SW-1:0];
    assign issue    = (state_reg == S_SCAN) && (idx_reg < SLOTS);
    assign find_hit = (state_reg == S_FIND) && !valid_reg[idx_s];

    assign vic_hit    = bo_hit_reg || ba_hit_reg;
    assign vic_idx    = bo_hit_reg ? bo_idx_reg : ba_idx_reg;
    assign vic_pos    = bo_hit_reg ? bo_pos_reg : ba_pos_reg;
    assign vic_inside = bo_hit_reg ? 1'b0 : ba_inside_reg;
    assign pick_add   = (state_reg == S_PICK) && vic_hit && (op_reg == sst_pkg::OP_ADD);

    assign mem_we    = find_hit || pick_add;
    assign mem_waddr = find_hit ? idx_s : vic_idx;

    sst_ram #(
        .WIDTH (PW),
        .DEPTH (SLOTS)
    ) u_pos_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata ({pz_reg, py_reg, px_reg}),
        .raddr (idx_s),
        .rdata (mem_rdata)
    );

    assign rx = mem_rdata[COORD_BITS-1:0];
    assign ry = mem_rdata[2*COORD_BITS-1:COORD_BITS];
    assign rz = mem_rdata[PW-1:2*COORD_BITS];
    assign ex = EW'(rx);
    assign ey = EW'(ry);
    assign ez = EW'(rz);
    assign dx = EW'(ox_reg) - ex;
    assign dy = EW'(oy_reg) - ey;
    assign dz = EW'(oz_reg) - ez;

    assign span_e = EW'($signed({1'b0, span_reg}));
    assign lox    = EW'(ox_reg) - span_e;
    assign hix    = EW'(ox_reg) + span_e;
    assign loz    = EW'(oz_reg) - span_e;
    assign hiz    = EW'(oz_reg) + span_e;
    assign ylo    = EW'(ymin_reg);
    assign yhi    = EW'(ymax_reg);

    assign r_inside = (ex >= lox) && (ex <= hix) && (ey >= ylo) && (ey <= yhi) &&
                      (ez >= loz) && (ez <= hiz);

    assign dsum = DSW'(b_qx_reg) + DSW'(b_qy_reg) + DSW'(b_qz_reg);

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            locked_reg    <= '0;
            free_reg      <= CW'(SLOTS);
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            p0_v_reg      <= 1'b0;
            a_v_reg       <= 1'b0;
            b_v_reg       <= 1'b0;
            bo_hit_reg    <= 1'b0;
            ba_hit_reg    <= 1'b0;
            bo_d_reg      <= '0;
            ba_d_reg      <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            oz_reg        <= '0;
            span_reg      <= '0;
            ymin_reg      <= '0;
            ymax_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sst_pkg::REG_ORIGIN_X:   ox_reg   <= cfg_data;
                    sst_pkg::REG_ORIGIN_Y:   oy_reg   <= cfg_data;
                    sst_pkg::REG_ORIGIN_Z:   oz_reg   <= cfg_data;
                    sst_pkg::REG_SPAN:       span_reg <= cfg_data[14:0];
                    sst_pkg::REG_MIN_HEIGHT: ymin_reg <= cfg_data;
                    sst_pkg::REG_MAX_HEIGHT: ymax_reg <= cfg_data;
                    default: ;
                endcase
            end

            p0_v_reg <= issue;
            a_v_reg  <= p0_v_reg;
            b_v_reg  <= a_v_reg;

            if (b_v_reg && b_cand_reg)
            begin
                if (!b_inside_reg && (dsum > bo_d_reg))
                begin
                    bo_hit_reg <= 1'b1;
                    bo_d_reg   <= dsum;
                end
                if (dsum > ba_d_reg)
                begin
                    ba_hit_reg <= 1'b1;
                    ba_d_reg   <= dsum;
                end
            end

            if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        idx_reg    <= '0;
                        bo_hit_reg <= 1'b0;
                        ba_hit_reg <= 1'b0;
                        bo_d_reg   <= '0;
                        ba_d_reg   <= '0;
                        unique case (in_op)
                            sst_pkg::OP_ADD:
                            begin
                                state_reg <= (free_reg == '0) ? S_SCAN : S_FIND;
                            end
                            sst_pkg::OP_REMOVE:
                            begin
                                state_reg <= S_DONE;
                                if (in_hit)
                                begin
                                    valid_reg[in_sidx]  <= 1'b0;
                                    locked_reg[in_sidx] <= 1'b0;
                                    free_reg            <= free_reg + 1'b1;
                                end
                            end
                            sst_pkg::OP_LOCK:
                            begin
                                state_reg <= S_DONE;
                                if (in_hit)
                                begin
                                    locked_reg[in_sidx] <= s_axis_tdata[54];
                                end
                            end
                            sst_pkg::OP_EVICT:
                            begin
                                state_reg <= S_SCAN;
                            end
                            default: ;
                        endcase
                    end
                end
                S_FIND:
                begin
                    if (find_hit)
                    begin
                        valid_reg[idx_s]  <= 1'b1;
                        locked_reg[idx_s] <= 1'b0;
                        free_reg          <= free_reg - 1'b1;
                        state_reg         <= S_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (issue)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else if (!p0_v_reg && !a_v_reg && !b_v_reg)
                    begin
                        state_reg <= S_PICK;
                    end
                end
                S_PICK:
                begin
                    state_reg <= S_DONE;
                    if (vic_hit)
                    begin
                        locked_reg[vic_idx] <= 1'b0;
                        if (op_reg == sst_pkg::OP_ADD)
                        begin
                            valid_reg[vic_idx] <= 1'b1;
                        end
                        else
                        begin
                            valid_reg[vic_idx] <= 1'b0;
                            free_reg           <= free_reg + 1'b1;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign vx   = res_vpos_reg[COORD_BITS-1:0];
    assign vy   = res_vpos_reg[2*COORD_BITS-1:COORD_BITS];
    assign vz   = res_vpos_reg[PW-1:2*COORD_BITS];
    assign vx32 = 32'(vx);
    assign vy32 = 32'(vy);
    assign vz32 = 32'(vz);

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg           <= in_op;
            px_reg           <= COORD_BITS'($signed(s_axis_tdata[15:0]));
            py_reg           <= COORD_BITS'($signed(s_axis_tdata[31:16]));
            pz_reg           <= COORD_BITS'($signed(s_axis_tdata[47:32]));
            res_status_reg   <= ((in_op == sst_pkg::OP_REMOVE || in_op == sst_pkg::OP_LOCK)
                                 && !in_hit) ? sst_pkg::STAT_EMPTY : sst_pkg::STAT_OK;
            res_new_slot_reg <= '0;
            res_vvalid_reg   <= 1'b0;
            res_vslot_reg    <= '0;
            res_vpos_reg     <= '0;
            res_inside_reg   <= 1'b0;
        end

        if (find_hit)
        begin
            res_new_slot_reg <= idx_s;
        end

        if (state_reg == S_PICK)
        begin
            if (vic_hit)
            begin
                res_vvalid_reg <= 1'b1;
                res_vslot_reg  <= vic_idx;
                res_vpos_reg   <= vic_pos;
                res_inside_reg <= vic_inside;
                if (op_reg == sst_pkg::OP_ADD)
                begin
                    res_new_slot_reg <= vic_idx;
                end
            end
            else
            begin
                res_status_reg <= sst_pkg::STAT_NO_VICTIM;
            end
        end

        p0_idx_reg  <= idx_s;
        p0_cand_reg <= valid_reg[idx_s] && !locked_reg[idx_s];

        a_idx_reg    <= p0_idx_reg;
        a_cand_reg   <= p0_cand_reg;
        a_pos_reg    <= mem_rdata;
        a_inside_reg <= r_inside;
        a_ax_reg     <= dx[EW-1] ? EW'(-dx) : EW'(dx);
        a_ay_reg     <= dy[EW-1] ? EW'(-dy) : EW'(dy);
        a_az_reg     <= dz[EW-1] ? EW'(-dz) : EW'(dz);

        b_idx_reg    <= a_idx_reg;
        b_cand_reg   <= a_cand_reg;
        b_pos_reg    <= a_pos_reg;
        b_inside_reg <= a_inside_reg;
        b_qx_reg     <= QW'(a_ax_reg) * QW'(a_ax_reg);
        b_qy_reg     <= QW'(a_ay_reg) * QW'(a_ay_reg);
        b_qz_reg     <= QW'(a_az_reg) * QW'(a_az_reg);

        if (b_v_reg && b_cand_reg)
        begin
            if (!b_inside_reg && (dsum > bo_d_reg))
            begin
                bo_idx_reg <= b_idx_reg;
                bo_pos_reg <= b_pos_reg;
            end
            if (dsum > ba_d_reg)
            begin
                ba_idx_reg    <= b_idx_reg;
                ba_pos_reg    <= b_pos_reg;
                ba_inside_reg <= b_inside_reg;
            end
        end

        if (out_load)
        begin
            out_data_reg <= {1'b0,
                             sst_pkg::FREE_W'(free_reg),
                             res_inside_reg,
                             vz32[15:0], vy32[15:0], vx32[15:0],
                             sst_pkg::SLOT_W'(res_vslot_reg),
                             res_vvalid_reg,
                             sst_pkg::SLOT_W'(res_new_slot_reg),
                             res_status_reg};
        end
    end

endmodule

/* hw/rtl/sst_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/sst_chk.sv */
// Port-level checker for the spatial slot table, bound to the top level.
// Uses sst_pkg and the assertion macro header.
`include "spatial_slot_table_with_far_eviction_assert.svh"

module sst_chk #(
    parameter int SLOTS = 64
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [sst_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic [sst_pkg::STATUS_W-1:0] status;
    logic                         vvalid;
    logic [sst_pkg::FREE_W-1:0]   free_count;
    logic [54:0]                  victim_rest;
    logic [sst_pkg::SLOT_W-1:0]   new_slot;

    assign status      = m_axis_tdata[sst_pkg::OUT_STATUS_LSB +: sst_pkg::STATUS_W];
    assign new_slot    = m_axis_tdata[sst_pkg::OUT_NEW_SLOT_LSB +: sst_pkg::SLOT_W];
    assign vvalid      = m_axis_tdata[sst_pkg::OUT_VVALID_LSB];
    assign victim_rest = m_axis_tdata[sst_pkg::OUT_VSLOT_LSB +: 55];
    assign free_count  = m_axis_tdata[sst_pkg::OUT_FREE_LSB +: sst_pkg::FREE_W];

    `SST_ASSERT_NOW(a_victim_ok, m_axis_tvalid && vvalid, status == sst_pkg::STAT_OK)
    `SST_ASSERT_NOW(a_no_victim_clear, m_axis_tvalid && !vvalid, victim_rest == '0)
    `SST_ASSERT_NOW(a_fail_no_slot, m_axis_tvalid && status != sst_pkg::STAT_OK, new_slot == '0)
    `SST_ASSERT_NOW(a_free_bound, m_axis_tvalid && SLOTS < 128, 32'(free_count) <= SLOTS)
    `SST_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

bind spatial_slot_table_with_far_eviction sst_chk #(
    .SLOTS (SLOTS)
) u_sst_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* sim/tb_spatial_slot_table_with_far_eviction.sv */
// Testbench for the spatial slot table with far-first eviction.
// It drives add, remove, set-lock and evict words under several region settings
// and checks each result word against a predictor kept in this file. Uses sst_pkg.
`timescale 1ns / 1ps

module tb_spatial_slot_table_with_far_eviction;
    import sst_pkg::*;

    localparam int NSLOT = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = NSLOT + 16;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   new_slot;
        logic                vvalid;
        logic [SLOT_W-1:0]   vslot;
        logic [POS_W-1:0]    vx;
        logic [POS_W-1:0]    vy;
        logic [POS_W-1:0]    vz;
        logic                vinside;
        logic [FREE_W-1:0]   free_cnt;
    } table_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [OPCODE_W-1:0]   s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // model of the slot table
    logic             tbl_valid [NSLOT];
    logic             tbl_locked[NSLOT];
    logic [POS_W-1:0] tbl_px    [NSLOT];
    logic [POS_W-1:0] tbl_py    [NSLOT];
    logic [POS_W-1:0] tbl_pz    [NSLOT];
    int               tbl_free;
    longint           org_x, org_y, org_z, box_span, box_min_y, box_max_y;

    table_result_t pending_results[$];
    int            error_count;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            hold_request;
    int            idle_cycles;

    spatial_slot_table_with_far_eviction dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic point_in_box(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                          logic [POS_W-1:0] z);
        longint sx;
        longint sy;
        longint sz;
        sx = longint'($signed(x));
        sy = longint'($signed(y));
        sz = longint'($signed(z));
        return sx >= org_x - box_span && sx <= org_x + box_span &&
               sy >= box_min_y && sy <= box_max_y &&
               sz >= org_z - box_span && sz <= org_z + box_span;
    endfunction

    function automatic longint dist_from_origin(int i);
        longint dx;
        longint dy;
        longint dz;
        dx = org_x - longint'($signed(tbl_px[i]));
        dy = org_y - longint'($signed(tbl_py[i]));
        dz = org_z - longint'($signed(tbl_pz[i]));
        return dx * dx + dy * dy + dz * dz;
    endfunction

    function automatic logic evict_farthest(inout table_result_t r);
        longint best_out;
        longint best_all;
        longint d;
        int     pick_out;
        int     pick_all;
        best_out = 0;
        best_all = 0;
        pick_out = -1;
        pick_all = -1;
        for (int i = 0; i < NSLOT; i++) begin
            if (tbl_valid[i] && !tbl_locked[i]) begin
                d = dist_from_origin(i);
                if (!point_in_box(tbl_px[i], tbl_py[i], tbl_pz[i]) && d > best_out) begin
                    best_out = d;
                    pick_out = i;
                end
                if (d > best_all) begin
                    best_all = d;
                    pick_all = i;
                end
            end
        end
        if (pick_out < 0)
            pick_out = pick_all;
        if (pick_out < 0)
            return 1'b0;
        r.vvalid  = 1'b1;
        r.vslot   = SLOT_W'(pick_out);
        r.vx      = tbl_px[pick_out];
        r.vy      = tbl_py[pick_out];
        r.vz      = tbl_pz[pick_out];
        r.vinside = point_in_box(tbl_px[pick_out], tbl_py[pick_out], tbl_pz[pick_out]);
        tbl_valid[pick_out]  = 1'b0;
        tbl_locked[pick_out] = 1'b0;
        tbl_free++;
        return 1'b1;
    endfunction

    function automatic table_result_t apply_table_op(logic [OPCODE_W-1:0] op,
                                                     logic [IN_DATA_W-1:0] word);
        table_result_t r;
        logic          ok;
        int            s;
        int            k;
        r = '{default: '0};
        s = int'(word[53:48]);
        if (op == OP_ADD) begin
            ok = 1'b1;
            if (tbl_free == 0)
                ok = evict_farthest(r);
            if (!ok) begin
                r.status = STAT_NO_VICTIM;
            end else begin
                k = 0;
                while (k < NSLOT && tbl_valid[k])
                    k++;
                if (k < NSLOT) begin
                    tbl_valid[k]  = 1'b1;
                    tbl_locked[k] = 1'b0;
                    tbl_px[k]     = word[15:0];
                    tbl_py[k]     = word[31:16];
                    tbl_pz[k]     = word[47:32];
                    if (tbl_free > 0)
                        tbl_free--;
                    r.new_slot = SLOT_W'(k);
                end else begin
                    r.status = STAT_NO_VICTIM;
                end
            end
        end else if (op == OP_REMOVE || op == OP_LOCK) begin
            if (!tbl_valid[s]) begin
                r.status = STAT_EMPTY;
            end else if (op == OP_REMOVE) begin
                tbl_valid[s]  = 1'b0;
                tbl_locked[s] = 1'b0;
                tbl_free++;
            end else begin
                tbl_locked[s] = word[54];
            end
        end else begin
            if (!evict_farthest(r))
                r.status = STAT_NO_VICTIM;
        end
        r.free_cnt = FREE_W'(tbl_free);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h, want %0h at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_word(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] x,
                             logic [POS_W-1:0] y, logic [POS_W-1:0] z,
                             logic [SLOT_W-1:0] s, logic lock);
        logic [IN_DATA_W-1:0] word;
        int                   gap;
        word = {1'b0, lock, s, z, y, x};
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(apply_table_op(op, word));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_region(int ox, int oy, int oz, int sp, int lo, int hi);
        logic [CFG_DATA_W-1:0] vals[6];
        logic [CFG_IDX_W-1:0]  idx[6];
        wait_drained();
        vals = '{CFG_DATA_W'(ox), CFG_DATA_W'(oy), CFG_DATA_W'(oz),
                 CFG_DATA_W'(sp & 32'h7FFF), CFG_DATA_W'(lo), CFG_DATA_W'(hi)};
        idx  = '{REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z, REG_SPAN,
                 REG_MIN_HEIGHT, REG_MAX_HEIGHT};
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        org_x     = longint'($signed(vals[0]));
        org_y     = longint'($signed(vals[1]));
        org_z     = longint'($signed(vals[2]));
        box_span  = longint'(vals[3] & 16'h7FFF);
        box_min_y = longint'($signed(vals[4]));
        box_max_y = longint'($signed(vals[5]));
    endtask

    function automatic logic [POS_W-1:0] pick_coord(longint centre);
        case ($urandom_range(5))
            0: return POS_W'($urandom);
            1: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            2: return POS_W'(centre);
            default: return POS_W'(centre + $signed($urandom_range(400)) - 200);
        endcase
    endfunction

    task automatic send_random_op();
        logic [OPCODE_W-1:0] op;
        int                  w;
        w = $urandom_range(99);
        op = w < 45 ? OP_ADD : w < 62 ? OP_REMOVE : w < 84 ? OP_LOCK : OP_EVICT;
        send_word(op, pick_coord(org_x), pick_coord(org_y), pick_coord(org_z),
                  SLOT_W'($urandom_range(NSLOT - 1)), 1'($urandom));
    endtask

    task automatic test_directed();
        send_word(OP_EVICT, 0, 0, 0, 0, 0);
        send_word(OP_REMOVE, 0, 0, 0, 6'd0, 0);
        send_word(OP_LOCK, 0, 0, 0, 6'd63, 1);
        send_word(OP_ADD, 0, 0, 0, 0, 0);
        send_word(OP_EVICT, 0, 0, 0, 0, 0);
        send_word(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 6'd63, 1);
        send_word(OP_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0);
        send_word(OP_ADD, 16'h8000, 16'h0000, 16'h7FFF, 0, 0);
        send_word(OP_LOCK, 0, 0, 0, 6'd2, 1);
        send_word(OP_LOCK, 0, 0, 0, 6'd3, 1);
        send_word(OP_EVICT, 0, 0, 0, 0, 0);
        send_word(OP_LOCK, 0, 0, 0, 6'd3, 0);
        send_word(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 0, 0);
        send_word(OP_ADD, 16'h0001, 16'h0000, 16'h0000, 0, 0);
        send_word(OP_ADD, 16'hFFFF, 16'h0000, 16'h0000, 0, 0);
        send_word(OP_EVICT, 0, 0, 0, 0, 0);
        send_word(OP_REMOVE, 0, 0, 0, 6'd2, 0);
        send_word(OP_REMOVE, 0, 0, 0, 6'd2, 0);
        send_word(OP_EVICT, 0, 0, 0, 0, 0);
        send_word(OP_EVICT, 0, 0, 0, 0, 0);
        send_word(OP_EVICT, 0, 0, 0, 0, 0);
        send_word(OP_EVICT, 0, 0, 0, 0, 0);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < NSLOT; i++)
            send_word(OP_ADD, pick_coord(org_x), pick_coord(org_y), pick_coord(org_z), 0, 0);
        send_word(OP_ADD, 16'h1234, 16'h8765, 16'h0F0F, 0, 0);
        send_word(OP_ADD, 16'h7FFF, 16'h8000, 16'h7FFF, 0, 0);
        for (int i = 0; i < NSLOT; i++)
            send_word(OP_LOCK, 0, 0, 0, SLOT_W'(i), 1);
        send_word(OP_ADD, 16'h0005, 16'h0005, 16'h0005, 0, 0);
        send_word(OP_EVICT, 0, 0, 0, 0, 0);
        send_word(OP_LOCK, 0, 0, 0, 6'd40, 0);
        send_word(OP_ADD, 16'h0005, 16'h0005, 16'h0005, 0, 0);
        for (int i = 0; i < NSLOT; i++)
            send_word(OP_REMOVE, 0, 0, 0, SLOT_W'(i), 0);
    endtask

    task automatic test_random_mix(int count);
        for (int i = 0; i < count; i++)
            send_random_op();
    endtask

    task automatic test_backpressure();
        hold_request = 400;
        for (int i = 0; i < 24; i++)
            send_random_op();
        wait_drained();
        for (int i = 0; i < 12; i++)
            send_random_op();
    endtask

    always @(posedge clk) begin : result_sink
        static int hold_left = 0;
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin : result_check
        table_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", 32'(m_axis_tdata), 0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[1:0] !== want.status)
                    report_mismatch("status", m_axis_tdata[1:0], want.status);
                if (m_axis_tdata[7:2] !== want.new_slot)
                    report_mismatch("new_slot", m_axis_tdata[7:2], want.new_slot);
                if (m_axis_tdata[8] !== want.vvalid)
                    report_mismatch("victim_valid", m_axis_tdata[8], want.vvalid);
                if (m_axis_tdata[14:9] !== want.vslot)
                    report_mismatch("victim_slot", m_axis_tdata[14:9], want.vslot);
                if (m_axis_tdata[30:15] !== want.vx)
                    report_mismatch("victim_x", m_axis_tdata[30:15], want.vx);
                if (m_axis_tdata[46:31] !== want.vy)
                    report_mismatch("victim_y", m_axis_tdata[46:31], want.vy);
                if (m_axis_tdata[62:47] !== want.vz)
                    report_mismatch("victim_z", m_axis_tdata[62:47], want.vz);
                if (m_axis_tdata[63] !== want.vinside)
                    report_mismatch("victim_inside", m_axis_tdata[63], want.vinside);
                if (m_axis_tdata[70:64] !== want.free_cnt)
                    report_mismatch("free_count", m_axis_tdata[70:64], want.free_cnt);
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ADD;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ORIGIN_X;
        cfg_data      = '0;
        error_count   = 0;
        hold_request  = 0;
        idle_cycles   = 0;
        send_idle_pct = 29;
        recv_idle_pct = 83;
        org_x = 0; org_y = 0; org_z = 0;
        box_span = 0; box_min_y = 0; box_max_y = 0;
        tbl_free = NSLOT;
        for (int i = 0; i < NSLOT; i++) begin
            tbl_valid[i]  = 1'b0;
            tbl_locked[i] = 1'b0;
            tbl_px[i] = '0; tbl_py[i] = '0; tbl_pz[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_region(100, -50, 200, 300, -100, 100);
        test_full_table();
        test_random_mix(100);

        send_idle_pct = 83;
        recv_idle_pct = 29;
        write_region(-32768, 32767, -32768, 32767, 32767, -32768);
        test_random_mix(150);
        write_region(32767, -32768, 32767, 0, -32768, 32767);
        test_random_mix(150);
        test_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_region(0, 0, 0, 1000, -1000, 1000);
        test_random_mix(100);

        wait_drained();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
